// File: rtl/jbt_pkg.sv
// Shared types, constants and helper functions for the JSON byte tokenizer.
`default_nettype none

package jbt_pkg;

    // lexeme length limit and the counter that tracks it (holds MAX_LEXEME+1)
    localparam int MAX_LEXEME = 64;
    localparam int LEN_W      = $clog2(MAX_LEXEME + 2);

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

    // scanner modes
    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_STR     = 4'd1;
    localparam logic [3:0] M_N0      = 4'd2;  // integer digits
    localparam logic [3:0] M_N1      = 4'd3;  // after '.'
    localparam logic [3:0] M_N2      = 4'd4;  // fraction digits
    localparam logic [3:0] M_N3      = 4'd5;  // after e/E
    localparam logic [3:0] M_N4      = 4'd6;  // after exponent sign
    localparam logic [3:0] M_N5      = 4'd7;  // exponent digits
    localparam logic [3:0] M_WORD    = 4'd8;
    localparam logic [3:0] M_SKIP    = 4'd9;
    localparam logic [3:0] M_SKIPSTR = 4'd10;

    // token kinds
    localparam logic [3:0] K_STRING = 4'd0;
    localparam logic [3:0] K_NUMBER = 4'd1;
    localparam logic [3:0] K_COLON  = 4'd2;
    localparam logic [3:0] K_COMMA  = 4'd3;
    localparam logic [3:0] K_LBRK   = 4'd4;
    localparam logic [3:0] K_RBRK   = 4'd5;
    localparam logic [3:0] K_LBRC   = 4'd6;
    localparam logic [3:0] K_RBRC   = 4'd7;
    localparam logic [3:0] K_TRUE   = 4'd8;
    localparam logic [3:0] K_FALSE  = 4'd9;
    localparam logic [3:0] K_NULL   = 4'd10;
    localparam logic [3:0] K_END    = 4'd11;
    localparam logic [3:0] K_ERROR  = 4'd12;

    // error codes
    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_OPEN_STR = 3'd1;
    localparam logic [2:0] E_BAD_NUM  = 3'd2;
    localparam logic [2:0] E_UNK_WORD = 3'd3;
    localparam logic [2:0] E_UNEXP    = 3'd4;
    localparam logic [2:0] E_TOO_LONG = 3'd5;

    // characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    // keyword spellings, last letter in the low byte
    localparam logic [39:0] KW_TRUE_L  = 40'h0074727565;
    localparam logic [39:0] KW_TRUE_U  = 40'h0054525545;
    localparam logic [39:0] KW_FALSE_L = 40'h66616C7365;
    localparam logic [39:0] KW_FALSE_U = 40'h46414C5345;
    localparam logic [39:0] KW_NULL_L  = 40'h006E756C6C;
    localparam logic [39:0] KW_NULL_U  = 40'h004E554C4C;

    typedef struct packed {
        logic [3:0]       mode;
        logic [23:0]      line;
        logic [31:0]      offs;
        logic [31:0]      tstart;
        logic [LEN_W-1:0] tlen;
        logic [39:0]      word;
        logic             qseen;
    } scan_st_t;

    typedef struct packed {
        logic [2:0]  err;
        logic [6:0]  len;
        logic [31:0] start;
        logic [23:0] line;
        logic [3:0]  kind;
    } res_t;

    typedef struct packed {
        logic       last;
        res_t       res;
    } res_ent_t;

    // up to two results from one item
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } res_push_t;

    function automatic res_t mk_res(input logic [3:0] kind, input logic [23:0] line,
                                    input logic [31:0] start, input logic [6:0] len,
                                    input logic [2:0] err);
        res_t r;
        r.kind  = kind;
        r.line  = line;
        r.start = start;
        r.len   = len;
        r.err   = err;
        return r;
    endfunction

    function automatic logic [6:0] cap_len(input logic [LEN_W-1:0] tlen);
        logic [6:0] v;
        if (tlen > LEN_W'(MAX_LEXEME))
            v = 7'(MAX_LEXEME);
        else
            v = 7'(tlen);
        return v;
    endfunction

    // keyword match; K_ERROR when the word is not a keyword
    function automatic logic [3:0] word_kind(input logic [39:0] word,
                                             input logic [LEN_W-1:0] tlen);
        logic [3:0] k;
        k = K_ERROR;
        if (tlen == LEN_W'(4)) begin
            if (word == KW_TRUE_L || word == KW_TRUE_U)
                k = K_TRUE;
            else if (word == KW_NULL_L || word == KW_NULL_U)
                k = K_NULL;
        end else if (tlen == LEN_W'(5)) begin
            if (word == KW_FALSE_L || word == KW_FALSE_U)
                k = K_FALSE;
        end
        return k;
    endfunction

    function automatic logic [23:0] line_inc(input logic [23:0] line);
        logic [23:0] v;
        if (line == LINE_MAX)
            v = line;
        else
            v = line + 24'd1;
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/jbt_scan.sv
// Next-state and result logic of the tokenizer for one byte or end marker.
`default_nettype none

module jbt_scan
    import jbt_pkg::*;
(
    input  scan_st_t  st,
    input  logic [7:0] in_byte,
    input  logic       in_eoi,
    output scan_st_t  st_next,
    output res_push_t push
);

    always_comb begin
        scan_st_t   ns;
        res_t       r0;
        res_t       r1;
        logic [1:0] cnt;
        logic       redo;
        logic       do_grow;
        logic       str_close;
        logic       is_d;
        logic       is_a;
        logic       is_e;
        logic [3:0] nm;
        logic [3:0] wk;
        logic [7:0] b;

        ns        = st;
        r0        = '0;
        r1        = '0;
        cnt       = 2'd0;
        redo      = 1'b0;
        do_grow   = 1'b0;
        str_close = 1'b0;
        nm        = M_IDLE;
        wk        = K_ERROR;
        b         = in_byte;
        is_d      = (b >= CH_0) && (b <= CH_9);
        is_a      = ((b >= CH_LA) && (b <= CH_LZ)) || ((b >= CH_UA) && (b <= CH_UZ));
        is_e      = (b == CH_LE) || (b == CH_UE);

        if (in_eoi) begin
            // flush whatever lexeme is open
            case (st.mode)
                M_STR:
                begin
                    r0 = mk_res(K_ERROR, st.line, st.tstart, cap_len(st.tlen), E_OPEN_STR);
                    cnt = 2'd1;
                end
                M_N0, M_N2, M_N5:
                begin
                    r0 = mk_res(K_NUMBER, st.line, st.tstart, cap_len(st.tlen), E_NONE);
                    cnt = 2'd1;
                end
                M_N1, M_N3, M_N4:
                begin
                    r0 = mk_res(K_ERROR, st.line, st.tstart, cap_len(st.tlen), E_BAD_NUM);
                    cnt = 2'd1;
                end
                M_WORD:
                begin
                    wk = word_kind(st.word, st.tlen);
                    r0 = mk_res(wk, st.line, st.tstart, cap_len(st.tlen),
                                (wk == K_ERROR) ? E_UNK_WORD : E_NONE);
                    cnt = 2'd1;
                end
                M_SKIPSTR:
                begin
                    if (!st.qseen) begin
                        r0 = mk_res(K_ERROR, st.line, st.tstart, cap_len(st.tlen),
                                    E_OPEN_STR);
                        cnt = 2'd1;
                    end
                end
                default:
                begin
                end
            endcase
            if (cnt == 2'd0)
                r0 = mk_res(K_END, st.line, st.offs, 7'd0, E_NONE);
            else
                r1 = mk_res(K_END, st.line, st.offs, 7'd0, E_NONE);
            cnt = cnt + 2'd1;
            ns.mode   = M_IDLE;
            ns.line   = 24'd1;
            ns.offs   = 32'd0;
            ns.tstart = 32'd0;
            ns.tlen   = '0;
            ns.word   = 40'd0;
            ns.qseen  = 1'b0;
        end else begin
            case (st.mode)
                M_STR:
                begin
                    if (b == CH_QUOTE) begin
                        do_grow   = 1'b1;
                        str_close = 1'b1;
                        ns.mode   = M_IDLE;
                    end else if (b == CH_COMMA || b == CH_COLON || b == CH_NL) begin
                        // unterminated string: emit what we have, then skip the line
                        r0 = mk_res(K_STRING, st.line, st.tstart, cap_len(st.tlen), E_NONE);
                        cnt = 2'd1;
                        ns.qseen = 1'b0;
                        ns.mode  = M_SKIPSTR;
                        if (b == CH_NL) begin
                            r1 = mk_res(K_ERROR, st.line, st.tstart, cap_len(st.tlen),
                                        E_OPEN_STR);
                            cnt = 2'd2;
                            ns.line = line_inc(st.line);
                            ns.mode = M_IDLE;
                        end
                    end else begin
                        do_grow = 1'b1;
                    end
                end
                M_N0, M_N1, M_N2, M_N3, M_N4, M_N5:
                begin
                    case (st.mode)
                        M_N0:
                            nm = is_d ? M_N0 : (b == CH_DOT) ? M_N1 : is_e ? M_N3 : M_IDLE;
                        M_N1:
                            nm = is_d ? M_N2 : M_IDLE;
                        M_N2:
                            nm = is_d ? M_N2 : is_e ? M_N3 : M_IDLE;
                        M_N3:
                            nm = (b == CH_PLUS || b == CH_MINUS) ? M_N4 :
                                 is_d ? M_N5 : M_IDLE;
                        M_N4:
                            nm = is_d ? M_N5 : M_IDLE;
                        default:
                            nm = is_d ? M_N5 : M_IDLE;
                    endcase
                    if (nm != M_IDLE) begin
                        ns.mode = nm;
                        do_grow = 1'b1;
                    end else begin
                        if (st.mode == M_N0 || st.mode == M_N2 || st.mode == M_N5)
                            r0 = mk_res(K_NUMBER, st.line, st.tstart, cap_len(st.tlen),
                                        E_NONE);
                        else
                            r0 = mk_res(K_ERROR, st.line, st.tstart, cap_len(st.tlen),
                                        E_BAD_NUM);
                        cnt  = 2'd1;
                        redo = 1'b1;
                    end
                end
                M_WORD:
                begin
                    if (is_a) begin
                        ns.word = {st.word[31:0], b};
                        do_grow = 1'b1;
                    end else begin
                        wk = word_kind(st.word, st.tlen);
                        r0 = mk_res(wk, st.line, st.tstart, cap_len(st.tlen),
                                    (wk == K_ERROR) ? E_UNK_WORD : E_NONE);
                        cnt  = 2'd1;
                        redo = 1'b1;
                    end
                end
                M_SKIP:
                begin
                    if (b == CH_NL) begin
                        ns.line = line_inc(st.line);
                        ns.mode = M_IDLE;
                    end
                end
                M_SKIPSTR:
                begin
                    if (b == CH_NL) begin
                        if (!st.qseen) begin
                            r0 = mk_res(K_ERROR, st.line, st.tstart, cap_len(st.tlen),
                                        E_OPEN_STR);
                            cnt = 2'd1;
                        end
                        ns.line = line_inc(st.line);
                        ns.mode = M_IDLE;
                    end else if (b == CH_QUOTE) begin
                        ns.qseen = 1'b1;
                    end
                end
                default:
                    redo = 1'b1;
            endcase

            // lexeme growth; the byte past the limit raises one too-long error
            if (do_grow) begin
                if (st.tlen < LEN_W'(MAX_LEXEME)) begin
                    ns.tlen = st.tlen + LEN_W'(1);
                end else if (st.tlen == LEN_W'(MAX_LEXEME)) begin
                    ns.tlen = LEN_W'(MAX_LEXEME + 1);
                    r0 = mk_res(K_ERROR, st.line, st.tstart, 7'(MAX_LEXEME), E_TOO_LONG);
                    cnt = 2'd1;
                end
            end
            if (str_close) begin
                if (cnt == 2'd0)
                    r0 = mk_res(K_STRING, st.line, st.tstart, cap_len(ns.tlen), E_NONE);
                else
                    r1 = mk_res(K_STRING, st.line, st.tstart, cap_len(ns.tlen), E_NONE);
                cnt = cnt + 2'd1;
            end

            // byte scanned from idle, also the byte that ended a number or word
            if (redo) begin
                ns.mode = M_IDLE;
                case (b)
                    CH_SP, CH_TAB:
                    begin
                    end
                    CH_NL:
                        ns.line = line_inc(st.line);
                    CH_QUOTE:
                    begin
                        ns.tstart = st.offs;
                        ns.tlen   = LEN_W'(1);
                        ns.mode   = M_STR;
                    end
                    CH_COLON, CH_COMMA, CH_LBRK, CH_RBRK, CH_LBRC, CH_RBRC:
                    begin
                        case (b)
                            CH_COLON: wk = K_COLON;
                            CH_COMMA: wk = K_COMMA;
                            CH_LBRK:  wk = K_LBRK;
                            CH_RBRK:  wk = K_RBRK;
                            CH_LBRC:  wk = K_LBRC;
                            default:  wk = K_RBRC;
                        endcase
                        if (cnt == 2'd0)
                            r0 = mk_res(wk, st.line, st.offs, 7'd1, E_NONE);
                        else
                            r1 = mk_res(wk, st.line, st.offs, 7'd1, E_NONE);
                        cnt = cnt + 2'd1;
                    end
                    default:
                    begin
                        if (is_d) begin
                            ns.tstart = st.offs;
                            ns.tlen   = LEN_W'(1);
                            ns.mode   = M_N0;
                        end else if (is_a) begin
                            ns.tstart = st.offs;
                            ns.tlen   = LEN_W'(1);
                            ns.mode   = M_WORD;
                            ns.word   = {32'd0, b};
                        end else begin
                            if (cnt == 2'd0)
                                r0 = mk_res(K_ERROR, st.line, st.offs, 7'd1, E_UNEXP);
                            else
                                r1 = mk_res(K_ERROR, st.line, st.offs, 7'd1, E_UNEXP);
                            cnt = cnt + 2'd1;
                            ns.mode = M_SKIP;
                        end
                    end
                endcase
            end
            ns.offs = st.offs + 32'd1;
        end

        st_next  = ns;
        push.cnt = cnt;
        push.r0  = r0;
        push.r1  = r1;
    end

endmodule

`default_nettype wire

// File: rtl/jbt_res_fifo.sv
// Small result queue: takes up to two results per cycle, hands out one.
`default_nettype none

module jbt_res_fifo
    import jbt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  res_push_t          push,
    output logic [FIFO_AW:0]   count,
    output logic               out_valid,
    input  logic               out_ready,
    output res_ent_t           out_ent
);

    res_ent_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_reg;
    logic [FIFO_AW-1:0]   wr_next;
    logic [FIFO_AW-1:0]   rd_reg;
    logic [FIFO_AW-1:0]   rd_next;
    logic [FIFO_AW:0]     cnt_reg;
    logic [FIFO_AW:0]     cnt_next;
    logic                 pop;
    res_ent_t             e0;
    res_ent_t             e1;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != '0);
    assign out_ent   = mem[rd_reg];
    assign count     = cnt_reg;

    assign e0.res  = push.r0;
    assign e0.last = (push.cnt == 2'd1);
    assign e1.res  = push.r1;
    assign e1.last = 1'b1;

    assign wr_next  = wr_reg + FIFO_AW'(push.cnt);
    assign rd_next  = rd_reg + FIFO_AW'(pop);
    assign cnt_next = cnt_reg + (FIFO_AW + 1)'(push.cnt) - (FIFO_AW + 1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem[wr_reg] <= e0;
        if (push.cnt == 2'd2)
            mem[wr_reg + FIFO_AW'(1)] <= e1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/json_byte_tokenizer.sv
// Top level of the streaming JSON byte tokenizer.
//
//  channel  | dir | payload                                        | accept
//  ---------+-----+------------------------------------------------+-------------------
//  s_axis   | in  | tdata[7:0] in_byte, tlast end_of_input          | s_tvalid & s_tready
//  m_axis   | out | tdata: kind, line, start, length, error code    | m_tvalid & m_tready
//           |     | tlast last_of_run                              |
//
// One byte per clock sustained: an accepted transaction sits in the input register, is
// scanned combinationally and its 0..2 results enter a four-entry queue, whose head
// shows on m_axis. Scanning waits until the queue has room for two; two-result items
// (terminator after a number or word, string cut by a newline, string close with
// overflow, end of input) enter the queue as two entries, handed out in turn.
// Reset: idle at line 1, offset 0, queue empty. m_tready stalls fill it, then drop s_tready.
`default_nettype none

module json_byte_tokenizer
    import jbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] token_kind, [27:4] line_number, [59:28] start_offset,
    // [66:60] lexeme_length, [69:67] error_code, [71:70] zero
    output logic [71:0] m_tdata,
    output logic        m_tlast    // last_of_run
);

    // input register
    logic             in_vld_reg;
    logic [7:0]       in_byte_reg;
    logic             in_eoi_reg;

    // scanner state
    scan_st_t         st_reg;
    scan_st_t         st_next;

    res_push_t        scan_push;
    res_push_t        fifo_push;
    logic [FIFO_AW:0] fifo_cnt;
    res_ent_t         out_ent;
    logic             proc_fire;

    // scan only when the queue can absorb a two-result item
    assign proc_fire = in_vld_reg && (fifo_cnt <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
    assign s_tready  = !in_vld_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg.mode   <= M_IDLE;
            st_reg.line   <= 24'd1;
            st_reg.offs   <= 32'd0;
            st_reg.tstart <= 32'd0;
            st_reg.tlen   <= '0;
            st_reg.word   <= 40'd0;
            st_reg.qseen  <= 1'b0;
        end else if (proc_fire) begin
            st_reg <= st_next;
        end
    end

    jbt_scan u_scan (
        .st      (st_reg),
        .in_byte (in_byte_reg),
        .in_eoi  (in_eoi_reg),
        .st_next (st_next),
        .push    (scan_push)
    );

    always_comb begin
        fifo_push = scan_push;
        if (!proc_fire)
            fifo_push.cnt = 2'd0;
    end

    jbt_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .count     (fifo_cnt),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ent   (out_ent)
    );

    assign m_tdata = {2'b00, out_ent.res.err, out_ent.res.len, out_ent.res.start,
                      out_ent.res.line, out_ent.res.kind};
    assign m_tlast = out_ent.last;

`ifndef SYNTH
    // end marker always yields at least the end token
    a_eoi_emits: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && in_eoi_reg |-> scan_push.cnt != 2'd0)
        else $error("end marker scanned without a result");

    // end marker returns the scanner to its reset state
    a_eoi_resets: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && in_eoi_reg |=> st_reg.mode == M_IDLE && st_reg.line == 24'd1 &&
                                    st_reg.offs == 32'd0)
        else $error("scanner not reset after end marker");

    // each scanned byte advances the offset by one
    a_offs_step: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && !in_eoi_reg |=> st_reg.offs == $past(st_reg.offs) + 32'd1)
        else $error("byte offset did not advance");

    // lexeme counter stops one past the limit
    a_tlen_cap: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.tlen <= LEN_W'(MAX_LEXEME + 1))
        else $error("lexeme length counter overran");

    // queue never overflows
    a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("result queue overflow");
`endif

endmodule

`default_nettype wire
